[rtl/lpg_pkg.sv]
package lpg_pkg;

  // Grid geometry and coordinate width
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned GRID_WIDTH  = 64;
  localparam int unsigned GRID_HEIGHT = 64;

  // Error term: holds span_x - span_y and stays well inside this width
  localparam int unsigned ERR_W = COORD_W + 3;

  // Queue between front and walker
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;

  // One classified line request
  typedef struct packed {
    coord_t                  cur_x;
    coord_t                  cur_y;
    coord_t                  tgt_x;
    coord_t                  tgt_y;
    coord_t                  span_x;
    coord_t                  span_y;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [ERR_W-1:0] err;
  } line_cmd_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_e;

  // Saturate a coordinate to the last row or column of the grid
  function automatic coord_t clamp_coord(input coord_t v, input int unsigned limit);
    logic [COORD_W:0] ext;
    logic [COORD_W:0] lim;
    ext = {1'b0, v};
    lim = (COORD_W + 1)'(limit);
    if (ext >= lim) begin
      return COORD_W'(limit - 1);
    end
    return v;
  endfunction

endpackage

[rtl/lpg_front.sv]
module lpg_front
  import lpg_pkg::*;
(
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  coord_t    start_x_i,
  input  coord_t    start_y_i,
  input  coord_t    end_x_i,
  input  coord_t    end_y_i,
  input  logic      q_ready_i,
  output logic      q_push_o,
  output line_cmd_t q_cmd_o
);

  coord_t sx, sy, ex, ey;
  logic   neg_x, neg_y;
  coord_t span_x, span_y;

  // Clamp endpoints onto the grid
  assign sx = clamp_coord(start_x_i, GRID_WIDTH);
  assign sy = clamp_coord(start_y_i, GRID_HEIGHT);
  assign ex = clamp_coord(end_x_i, GRID_WIDTH);
  assign ey = clamp_coord(end_y_i, GRID_HEIGHT);

  // Direction and absolute span per axis
  assign neg_x  = !(sx < ex);
  assign neg_y  = !(sy < ey);
  assign span_x = neg_x ? (sx - ex) : (ex - sx);
  assign span_y = neg_y ? (sy - ey) : (ey - sy);

  // Classified command, initial error = |dx| - |dy|
  always_comb begin
    q_cmd_o.cur_x  = sx;
    q_cmd_o.cur_y  = sy;
    q_cmd_o.tgt_x  = ex;
    q_cmd_o.tgt_y  = ey;
    q_cmd_o.span_x = span_x;
    q_cmd_o.span_y = span_y;
    q_cmd_o.neg_x  = neg_x;
    q_cmd_o.neg_y  = neg_y;
    q_cmd_o.err    = $signed({{(ERR_W-COORD_W){1'b0}}, span_x})
                   - $signed({{(ERR_W-COORD_W){1'b0}}, span_y});
  end

  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

endmodule

[rtl/lpg_queue.sv]
module lpg_queue
  import lpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_cmd_t push_cmd_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output line_cmd_t head_o
);

  line_cmd_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (ready_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");
`endif

endmodule

[rtl/lpg_walker.sv]
module lpg_walker
  import lpg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  line_cmd_t q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output coord_t    pixel_x_o,
  output coord_t    pixel_y_o,
  output logic      last_pixel_o
);

  walk_state_e state_q, state_d;
  line_cmd_t   cmd_q, cmd_d;
  logic        out_valid_q, out_valid_d;
  coord_t      pix_x_q, pix_y_q;
  logic        last_q;

  logic                    done;
  logic                    emit;
  logic                    step_x, step_y;
  logic signed [ERR_W:0]   e2, dx_ext, dy_neg;
  logic signed [ERR_W:0]   err_sum;

  // Error term decision for the current pixel
  assign done    = (cmd_q.cur_x == cmd_q.tgt_x) && (cmd_q.cur_y == cmd_q.tgt_y);
  assign e2      = {cmd_q.err, 1'b0};
  assign dx_ext  = $signed({{(ERR_W+1-COORD_W){1'b0}}, cmd_q.span_x});
  assign dy_neg  = -$signed({{(ERR_W+1-COORD_W){1'b0}}, cmd_q.span_y});
  assign step_x  = (e2 > dy_neg);
  assign step_y  = (e2 < dx_ext);
  assign err_sum = {cmd_q.err[ERR_W-1], cmd_q.err}
                 + (step_x ? dy_neg : '0)
                 + (step_y ? dx_ext : '0);

  // A pixel goes out when the output register is free or being drained
  assign emit    = (state_q == WALK_RUN) && (!out_valid_q || out_ready_i);
  assign q_pop_o = (state_q == WALK_IDLE) && q_valid_i;

  // Next state, walk registers and output slot
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      WALK_IDLE: begin
        if (q_valid_i) begin
          cmd_d   = q_head_i;
          state_d = WALK_RUN;
        end
      end
      WALK_RUN: begin
        if (emit) begin
          out_valid_d = 1'b1;
          if (done) begin
            state_d = WALK_IDLE;
          end else begin
            cmd_d.err = err_sum[ERR_W-1:0];
            if (step_x) begin
              cmd_d.cur_x = cmd_q.neg_x ? cmd_q.cur_x - 1'b1 : cmd_q.cur_x + 1'b1;
            end
            if (step_y) begin
              cmd_d.cur_y = cmd_q.neg_y ? cmd_q.cur_y - 1'b1 : cmd_q.cur_y + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WALK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (emit) begin
      pix_x_q <= cmd_q.cur_x;
      pix_y_q <= cmd_q.cur_y;
      last_q  <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = last_q;

`ifndef SYNTHESIS
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == WALK_RUN))
    else $error("line load did not start a walk");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && done) |=> (state_q == WALK_IDLE) && out_valid_q && last_q)
    else $error("end point did not close the line");

  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !done) |=> (cmd_q.cur_x != $past(cmd_q.cur_x))
                     || (cmd_q.cur_y != $past(cmd_q.cur_y)))
    else $error("walk step did not move the pixel");
`endif

endmodule

[rtl/line_pixel_generator.sv]
// Path: the first pixel of a line passes the queue write, then the walker load,
// then the walker output register, when the walker is idle.
// Throughput: one pixel per cycle while out_ready_i is high; after a line of
// max(|dx|,|dy|)+1 pixels the walker returns to idle to load the next. A 2-entry queue lets
// requests be taken while a line is still being walked.
// Reset: rst_ni asynchronous active low, clears queue and walker to idle.
module line_pixel_generator
  import lpg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output logic   last_pixel_o
);

  logic      q_ready, q_push, q_valid, q_pop;
  line_cmd_t push_cmd, head_cmd;

  // Front: request transfer and classification
  lpg_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // Command queue
  lpg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // Back: pixel walk
  lpg_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule

[test/line_pixel_generator_test.sv]
module line_pixel_generator_test
  import lpg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_LINES = 78;
  localparam int unsigned PHASE_ITEMS  = 16;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned MAX_PIXELS   = 64;

  // Idle/stall mix, switched by the number of accepted requests
  typedef enum logic [1:0] {
    PH_NO_IDLE,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } idle_phase_e;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } line_req_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef logic signed [ERR_W-1:0] err_t;

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_ready_o;
  coord_t start_x_i    = '0;
  coord_t start_y_i    = '0;
  coord_t end_x_i      = '0;
  coord_t end_y_i      = '0;
  logic   out_valid_o;
  logic   out_ready_i  = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  line_req_t   line_requests[$];
  pixel_t      expected_pixels[$];
  int unsigned total_lines;
  int unsigned lines_sent     = 0;
  int unsigned lines_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  line_pixel_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_pixel_o(last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Walk the error-term line and queue every pixel it plots.
  // Coordinates cannot leave the 64x64 grid at this size, so no saturation.
  task automatic trace_line(input line_req_t req);
    coord_t                x, y, span_x, span_y;
    logic                  neg_x, neg_y, done;
    err_t                  dx, dy, err;
    logic signed [ERR_W:0] dbl;
    int unsigned           n;
    x      = req.sx;
    y      = req.sy;
    neg_x  = !(req.sx < req.ex);
    neg_y  = !(req.sy < req.ey);
    span_x = neg_x ? req.sx - req.ex : req.ex - req.sx;
    span_y = neg_y ? req.sy - req.ey : req.ey - req.sy;
    dx     = err_t'(span_x);
    dy     = -err_t'(span_y);
    err    = dx + dy;
    n      = 0;
    done   = 1'b0;
    while (!done && n < MAX_PIXELS) begin
      done = (x == req.ex) && (y == req.ey);
      expected_pixels.push_back('{x: x, y: y, last: done});
      n++;
      if (!done) begin
        dbl = (ERR_W+1)'(2 * err);
        if (dbl > dy) begin
          err = err + dy;
          x   = neg_x ? x - 1'b1 : x + 1'b1;
        end
        if (dbl < dx) begin
          err = err + dx;
          y   = neg_y ? y - 1'b1 : y + 1'b1;
        end
      end
    end
  endtask

  task automatic add_line(input int sx, input int sy, input int ex, input int ey);
    line_requests.push_back('{sx: coord_t'(sx), sy: coord_t'(sy),
                              ex: coord_t'(ex), ey: coord_t'(ey)});
  endtask

  function automatic idle_phase_e cur_phase();
    return idle_phase_e'((lines_accepted / PHASE_ITEMS) % 4);
  endfunction

  // Driver: new request or hold at the falling edge, random sink stalls
  always @(negedge clk_i) begin
    line_req_t   req;
    int unsigned gap_pct;
    int unsigned stall_pct;
    case (cur_phase())
      PH_SRC_IDLE: begin
        gap_pct   = 52;
        stall_pct = 0;
      end
      PH_SINK_STALL: begin
        gap_pct   = 0;
        stall_pct = 52;
      end
      PH_BOTH: begin
        gap_pct   = 19;
        stall_pct = 19;
      end
      default: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
    endcase
    if (rst_ni && lines_sent == lines_accepted) begin
      if (line_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req = line_requests.pop_front();
        start_x_i  <= req.sx;
        start_y_i  <= req.sy;
        end_x_i    <= req.ex;
        end_y_i    <= req.ey;
        in_valid_i <= 1'b1;
        lines_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: check each pixel transfer, predict each accepted request
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel x", int'(pixel_x_o), -1);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_x_o !== want.x)
          report_mismatch("pixel_x", int'(pixel_x_o), int'(want.x));
        if (pixel_y_o !== want.y)
          report_mismatch("pixel_y", int'(pixel_y_o), int'(want.y));
        if (last_pixel_o !== want.last)
          report_mismatch("last_pixel", int'(last_pixel_o), int'(want.last));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      trace_line('{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i});
      lines_accepted++;
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] watchdog expired", $time);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    int          sx, sy;

    // Directed: points, axis lines, diagonals, all eight octants, unit steps
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(42, 21, 42, 21);
    add_line(0, 0, 63, 0);
    add_line(63, 63, 0, 63);
    add_line(0, 63, 0, 0);
    add_line(63, 0, 63, 63);
    add_line(0, 0, 63, 63);
    add_line(63, 63, 0, 0);
    add_line(0, 63, 63, 0);
    add_line(63, 0, 0, 63);
    add_line(5, 10, 60, 30);
    add_line(60, 30, 5, 10);
    add_line(5, 30, 60, 10);
    add_line(60, 10, 5, 30);
    add_line(10, 5, 30, 60);
    add_line(30, 60, 10, 5);
    add_line(10, 60, 30, 5);
    add_line(30, 5, 10, 60);
    add_line(20, 20, 21, 21);
    add_line(33, 33, 32, 33);
    add_line(21, 42, 21, 43);

    // Random: mostly arbitrary lines, some short ones and some single points
    repeat (RANDOM_LINES) begin
      kind = $urandom_range(9);
      sx   = $urandom_range(63);
      sy   = $urandom_range(63);
      if (kind < 7) begin
        add_line(sx, sy, $urandom_range(63), $urandom_range(63));
      end else if (kind < 9) begin
        add_line(sx, sy, sx ^ $urandom_range(3), sy ^ $urandom_range(3));
      end else begin
        add_line(sx, sy, sx, sy);
      end
    end
    total_lines = line_requests.size();

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (lines_accepted != total_lines || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
